// File: src/gcode_word_parser_top_defines.svh
// Assertion macros used by the G-code word parser top level.
// No dependencies; included by the top level, which supplies clk and arst_n.
`ifndef GCODE_WORD_PARSER_TOP_DEFINES_SVH
`define GCODE_WORD_PARSER_TOP_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define GWP_ASSERT_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Checks that an antecedent implies a consequent on the following edge.
`define GWP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/gwp_pkg.sv
// Package for the G-code word parser: result type, phase encoding,
// character codes and the letter classifier. No dependencies.
`default_nettype none

package gwp_pkg;

	localparam int GWP_MAX_DIGITS = 12;
	localparam int MANT_W         = 40;
	localparam int TDATA_W        = 56;

	typedef enum logic [1:0] {
		PH_WAIT   = 2'd0,
		PH_LETTER = 2'd1,
		PH_INT    = 2'd2,
		PH_FRAC   = 2'd3
	} phase_t;

	localparam logic [2:0] CLS_FEED    = 3'd0;
	localparam logic [2:0] CLS_ANGLE   = 3'd1;
	localparam logic [2:0] CLS_LENGTH  = 3'd2;
	localparam logic [2:0] CLS_IGNORED = 3'd3;
	localparam logic [2:0] CLS_UNKNOWN = 3'd4;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	localparam logic [4:0] LETTER_N = 5'd13;

	typedef struct packed {
		logic              word_valid;
		logic [4:0]        letter;
		logic [2:0]        word_class;
		logic              is_negative;
		logic [MANT_W-1:0] mantissa;
		logic [3:0]        fraction_digits;
		logic              overflow;
		logic              double_minus;
		logic              line_end;
	} res_t;

	// Letters are numbered from A = 0 to Z = 25.
	function automatic logic [2:0] classify(input logic [4:0] l);
		logic [2:0] cls;
		case (l) inside
			5'd5:                                       cls = CLS_FEED;
			5'd0, 5'd1, 5'd2:                           cls = CLS_ANGLE;
			5'd8, 5'd9, 5'd10, 5'd17, [5'd20:5'd25]:    cls = CLS_LENGTH;
			5'd6, 5'd12, 5'd13:                         cls = CLS_IGNORED;
			default:                                    cls = CLS_UNKNOWN;
		endcase
		return cls;
	endfunction

endpackage

`default_nettype wire

// File: src/gwp_core.sv
// Per-character parse step of the G-code word parser: word state registers
// and the next-state and result logic. Depends on gwp_pkg.
`default_nettype none

module gwp_core import gwp_pkg::*; #(
	parameter int MAX_DIGITS = GWP_MAX_DIGITS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] character,
	input  wire logic       end_of_line,
	output logic            res_valid,
	output res_t            res
);

	localparam logic [63:0] LIM   = (64'd10 ** MAX_DIGITS) - 64'd1;
	localparam int          ACC_W = $clog2(LIM + 64'd1);
	localparam int          EXT_W = ACC_W + 4;

	phase_t           phase_q, phase_d;
	logic [5:0]       depth_q, depth_n;
	logic [4:0]       letter_q, letter_d;
	logic             sign_q, sign_d;
	logic [ACC_W-1:0] acc_q, acc_d;
	logic [3:0]       frac_q, frac_d;
	logic             ovf_q, ovf_d;
	logic             mrep_q, mrep_d;

	logic [7:0]       c;
	logic             is_letter, is_digit, is_point, emit_word;
	logic [3:0]       dig;
	logic [EXT_W-1:0] acc_x10;
	logic             fits, frac_full;
	phase_t           phase_w;

	always_comb begin
		c = character;
		if (character >= CH_LOWER_A && character <= CH_LOWER_Z) begin
			c = character - CASE_OFFSET;
		end
		depth_n = depth_q;
		if (c == CH_LPAREN) begin
			depth_n = depth_q + 6'd1;
		end else if (c == CH_RPAREN) begin
			depth_n = depth_q - 6'd1;
		end
		is_letter = (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
		is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
		is_point  = (c == CH_DOT) || (c == CH_COMMA);
		dig       = is_digit ? c[3:0] : 4'd0;
		acc_x10   = (EXT_W'(acc_q) << 3) + (EXT_W'(acc_q) << 1) + EXT_W'(dig);
		fits      = acc_x10 <= EXT_W'(LIM);
		frac_full = (32'(frac_q) >= MAX_DIGITS) || (frac_q == 4'hF);
		emit_word = (depth_n == 6'd0) && (phase_q == PH_INT || phase_q == PH_FRAC)
			&& is_letter;
	end

	always_comb begin
		phase_w  = emit_word ? PH_WAIT : phase_q;
		phase_d  = phase_w;
		letter_d = letter_q;
		sign_d   = sign_q;
		acc_d    = acc_q;
		frac_d   = frac_q;
		ovf_d    = ovf_q;
		mrep_d   = mrep_q;
		if (depth_n == 6'd0) begin
			unique case (phase_w)
				PH_WAIT: begin
					if (is_letter) begin
						phase_d  = PH_LETTER;
						letter_d = 5'(c - CH_UPPER_A);
						sign_d   = 1'b0;
						acc_d    = '0;
						frac_d   = 4'd0;
						ovf_d    = 1'b0;
						mrep_d   = 1'b0;
					end
				end
				PH_LETTER: begin
					if (c == CH_MINUS) begin
						sign_d  = 1'b1;
						phase_d = PH_INT;
					end else if (is_digit) begin
						acc_d   = ACC_W'(dig);
						phase_d = PH_INT;
					end else if (is_point) begin
						phase_d = PH_FRAC;
						frac_d  = 4'd0;
					end
				end
				PH_INT: begin
					if (c == CH_MINUS && sign_q) begin
						mrep_d = 1'b1;
					end
					if (is_digit) begin
						if (fits) begin
							acc_d = acc_x10[ACC_W-1:0];
						end else begin
							acc_d = LIM[ACC_W-1:0];
							ovf_d = 1'b1;
						end
					end else if (is_point) begin
						phase_d = PH_FRAC;
						frac_d  = 4'd0;
					end
				end
				PH_FRAC: begin
					if (is_digit) begin
						if (frac_full || !fits) begin
							ovf_d = 1'b1;
						end else begin
							acc_d  = acc_x10[ACC_W-1:0];
							frac_d = frac_q + 4'd1;
						end
					end
				end
				default: begin
					phase_d = PH_WAIT;
				end
			endcase
		end
	end

	always_comb begin
		res_valid = accept && (emit_word || end_of_line);
		res       = '0;
		if (emit_word) begin
			res.word_valid      = 1'b1;
			res.letter          = letter_q;
			res.word_class      = classify(letter_q);
			res.is_negative     = sign_q;
			res.mantissa        = MANT_W'(acc_q);
			res.fraction_digits = frac_q;
			res.overflow        = ovf_q;
			res.double_minus    = mrep_q;
		end else if ((depth_n == 6'd0) && (phase_d == PH_INT || phase_d == PH_FRAC)) begin
			res.word_valid      = 1'b1;
			res.letter          = letter_d;
			res.word_class      = classify(letter_d);
			res.is_negative     = sign_d;
			res.mantissa        = MANT_W'(acc_d);
			res.fraction_digits = frac_d;
			res.overflow        = ovf_d;
			res.double_minus    = mrep_d;
		end
		res.line_end = end_of_line;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT;
			depth_q  <= 6'd0;
			letter_q <= LETTER_N;
			sign_q   <= 1'b0;
			acc_q    <= '0;
			frac_q   <= 4'd0;
			ovf_q    <= 1'b0;
			mrep_q   <= 1'b0;
		end else if (accept) begin
			if (end_of_line) begin
				phase_q  <= PH_WAIT;
				depth_q  <= 6'd0;
				letter_q <= LETTER_N;
				sign_q   <= 1'b0;
				acc_q    <= '0;
				frac_q   <= 4'd0;
				ovf_q    <= 1'b0;
				mrep_q   <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				depth_q  <= depth_n;
				letter_q <= letter_d;
				sign_q   <= sign_d;
				acc_q    <= acc_d;
				frac_q   <= frac_d;
				ovf_q    <= ovf_d;
				mrep_q   <= mrep_d;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/gcode_word_parser_top.sv
// G-code word parser top level: input stream, parse step, output register
// with skid stage. Depends on gwp_pkg, gwp_core and the defines header.
//
// The slave stream carries one ASCII byte of a G-code line per transfer,
// with tlast on the last byte of the line. The master stream carries one
// parsed word per transfer; tlast marks the result that closes the line.
// A transfer closing the line with no completed word has word_valid low and
// all other data bits zero. Other bytes that complete no word give no transfer.
// One byte is taken every cycle while the skid entry is empty. A result is
// registered behind the parse step, in the output register or, while that
// register is held by the receiver, in the skid entry.
// The output register is backed by a one-entry skid stage, so the input
// keeps flowing while one result waits. The input stalls for as long as
// the skid entry holds a result, up to and including the edge at which the
// receiver takes the output register.
// Reset clears the parser to the start of a line with no open comment and
// empties both output entries.
`default_nettype none
`include "gcode_word_parser_top_defines.svh"

module gcode_word_parser_top import gwp_pkg::*; #(
	parameter int MAX_DIGITS = GWP_MAX_DIGITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	// [7:0] character
	input  wire logic [7:0]         s_axis_tdata,
	input  wire logic               s_axis_tlast,
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	// [0] word_valid, [5:1] letter, [8:6] word_class, [9] is_negative,
	// [49:10] mantissa, [53:50] fraction_digits, [54] overflow, [55] double_minus
	output logic [TDATA_W-1:0]      m_axis_tdata,
	output logic                    m_axis_tlast
);

	logic accept, res_valid, pop;
	res_t res, out_q, skid_q;
	logic out_v_q, skid_v_q;

	assign s_axis_tready = !skid_v_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign pop           = out_v_q && m_axis_tready;

	gwp_core #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.character(s_axis_tdata),
		.end_of_line(s_axis_tlast),
		.res_valid(res_valid),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || pop) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (res_valid) begin
				out_q <= res;
			end
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tlast  = out_q.line_end;
	assign m_axis_tdata  = {out_q.double_minus, out_q.overflow, out_q.fraction_digits,
		out_q.mantissa, out_q.is_negative, out_q.word_class, out_q.letter,
		out_q.word_valid};

	`GWP_ASSERT_HOLDS(a_skid_behind_out, !skid_v_q || out_v_q, "skid full with output empty")
	`GWP_ASSERT_NEXT(a_stall_keeps_out, out_v_q && !m_axis_tready, out_v_q, "result lost")
	`GWP_ASSERT_HOLDS(a_empty_closes_line, !out_v_q || out_q.word_valid || out_q.line_end,
		"result with neither word nor line end")
	`GWP_ASSERT_NEXT(a_skid_fill, out_v_q && !m_axis_tready && res_valid, skid_v_q,
		"stalled result not held in skid")

endmodule

`default_nettype wire

// File: bench/gcode_word_parser_top_test.sv
// Self-checking bench for gcode_word_parser_top: drives G-code lines byte by byte on the
// input stream and checks every parsed word against an in-bench parser model.
// Depends on gwp_pkg and the gcode_word_parser_top RTL.
`timescale 1ns / 1ps

module gcode_word_parser_top_test;
	import gwp_pkg::*;

	class gcode_word_tracker;
		typedef struct {
			bit                word_valid;
			logic [4:0]        letter;
			logic [2:0]        word_class;
			bit                is_negative;
			logic [MANT_W-1:0] mantissa;
			logic [3:0]        fraction_digits;
			bit                overflow;
			bit                double_minus;
			bit                line_end;
		} word_t;

		word_t       expected_words[$];
		int unsigned failures;
		phase_t      parse_phase;
		logic [5:0]  paren_depth;
		logic [4:0]  word_letter;
		bit          minus_sign;
		logic [63:0] digits;
		logic [3:0]  frac_count;
		bit          saturated;
		bit          extra_minus;
		logic [63:0] mant_cap;

		function new();
			failures = 0;
			mant_cap = 64'd1;
			repeat (GWP_MAX_DIGITS) mant_cap = mant_cap * 64'd10;
			mant_cap = mant_cap - 64'd1;
			clear_line();
		endfunction

		function void open_word(logic [4:0] l);
			word_letter = l;
			parse_phase = PH_LETTER;
			minus_sign  = 1'b0;
			digits      = '0;
			frac_count  = '0;
			saturated   = 1'b0;
			extra_minus = 1'b0;
		endfunction

		function void clear_line();
			open_word(LETTER_N);
			parse_phase = PH_WAIT;
			paren_depth = '0;
		endfunction

		function bit fits(logic [63:0] d);
			return digits <= (mant_cap - d) / 64'd10;
		endfunction

		function void record_word(bit valid, bit at_end);
			word_t      w;
			logic [7:0] ch;
			w = '{default: 0};
			if (valid) begin
				ch = CH_UPPER_A + 8'(word_letter);
				w.word_valid = 1'b1;
				w.letter     = word_letter;
				case (ch)
					"F":                     w.word_class = CLS_FEED;
					"A", "B", "C":           w.word_class = CLS_ANGLE;
					"I", "J", "K", "R", "U", "V", "W", "X", "Y", "Z":
						w.word_class = CLS_LENGTH;
					"G", "M", "N":           w.word_class = CLS_IGNORED;
					default:                 w.word_class = CLS_UNKNOWN;
				endcase
				w.is_negative     = minus_sign;
				w.mantissa        = digits[MANT_W-1:0];
				w.fraction_digits = frac_count;
				w.overflow        = saturated;
				w.double_minus    = extra_minus;
			end
			w.line_end = at_end;
			expected_words.push_back(w);
		endfunction

		function void note_byte(logic [7:0] raw, logic eol);
			logic [7:0]  c;
			logic [63:0] d;
			bit          letter_c;
			bit          digit_c;
			bit          point_c;
			bit          produced;
			c = raw;
			produced = 1'b0;
			if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
				c = c - CASE_OFFSET;
			if (c == CH_LPAREN)
				paren_depth = paren_depth + 6'd1;
			if (c == CH_RPAREN)
				paren_depth = paren_depth - 6'd1;
			letter_c = c >= CH_UPPER_A && c <= CH_UPPER_Z;
			digit_c  = c >= CH_ZERO && c <= CH_NINE;
			point_c  = c == CH_DOT || c == CH_COMMA;
			d = digit_c ? 64'(c - CH_ZERO) : 64'd0;

			if (paren_depth == 0 && parse_phase >= PH_INT && letter_c) begin
				record_word(1'b1, eol);
				produced = 1'b1;
				parse_phase = PH_WAIT;
			end

			if (paren_depth == 0) begin
				case (parse_phase)
					PH_WAIT: begin
						if (letter_c)
							open_word(5'(c - CH_UPPER_A));
					end
					PH_LETTER: begin
						if (c == CH_MINUS) begin
							minus_sign = 1'b1;
							parse_phase = PH_INT;
						end
						if (digit_c) begin
							digits = d;
							parse_phase = PH_INT;
						end
						if (point_c) begin
							parse_phase = PH_FRAC;
							frac_count = '0;
						end
					end
					PH_INT: begin
						if (c == CH_MINUS && minus_sign)
							extra_minus = 1'b1;
						if (digit_c) begin
							if (fits(d)) begin
								digits = digits * 64'd10 + d;
							end else begin
								digits = mant_cap;
								saturated = 1'b1;
							end
						end else if (point_c) begin
							parse_phase = PH_FRAC;
							frac_count = '0;
						end
					end
					default: begin
						if (digit_c) begin
							if (frac_count >= GWP_MAX_DIGITS || frac_count >= 15 || !fits(d)) begin
								saturated = 1'b1;
							end else begin
								digits = digits * 64'd10 + d;
								frac_count = frac_count + 4'd1;
							end
						end
					end
				endcase
			end

			if (eol) begin
				if (!produced)
					record_word(paren_depth == 0 && parse_phase >= PH_INT, 1'b1);
				clear_line();
			end
		endfunction

		function void compare(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s mismatch: expected %0d, actual %0d", field, want, got);
				failures++;
			end
		endfunction

		function void check_word(logic [TDATA_W-1:0] data, logic last);
			word_t w;
			if (expected_words.size() == 0) begin
				$error("unexpected word transfer: tdata=%h tlast=%b", data, last);
				failures++;
				return;
			end
			w = expected_words.pop_front();
			compare("word_valid", w.word_valid, data[0]);
			compare("letter", w.letter, data[5:1]);
			compare("word_class", w.word_class, data[8:6]);
			compare("is_negative", w.is_negative, data[9]);
			compare("mantissa", w.mantissa, data[49:10]);
			compare("fraction_digits", w.fraction_digits, data[53:50]);
			compare("overflow", w.overflow, data[54]);
			compare("double_minus", w.double_minus, data[55]);
			compare("line_end", w.line_end, last);
		endfunction
	endclass

	localparam int QUIET_LIMIT = 5000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata = '0;
	logic               s_axis_tlast = 1'b0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic               m_axis_tlast;

	gcode_word_tracker tracker = new();
	logic [7:0]        line_q[$];
	int unsigned       bytes_sent = 0;
	int unsigned       quiet_cycles = 0;
	int unsigned       rx_hold_len = 0;
	bit                tx_idle_on = 1'b1;
	bit                rx_stall_on = 1'b1;

	gcode_word_parser_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_word(m_axis_tdata, m_axis_tlast);
			if (s_axis_tvalid && s_axis_tready)
				tracker.note_byte(s_axis_tdata, s_axis_tlast);
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$error("no transfer for %0d cycles", QUIET_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		@(posedge clk);
		forever begin
			if (rx_hold_len != 0) begin
				m_axis_tready <= 1'b0;
				repeat (rx_hold_len) @(posedge clk);
				rx_hold_len = 0;
			end else if (rx_stall_on && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	function automatic logic [7:0] random_letter();
		logic [7:0] ch;
		ch = CH_UPPER_A + 8'($urandom_range(0, 25));
		if ($urandom_range(0, 1) == 1)
			ch = ch + CASE_OFFSET;
		return ch;
	endfunction

	function automatic logic [7:0] random_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic int digit_count();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 16) : $urandom_range(0, 5);
	endfunction

	function automatic void queue_text(string s);
		for (int i = 0; i < s.len(); i++)
			line_q.push_back(s[i]);
	endfunction

	function automatic void add_comment();
		line_q.push_back(CH_LPAREN);
		repeat ($urandom_range(0, 4)) begin
			if ($urandom_range(0, 5) == 0)
				add_comment();
			else
				line_q.push_back(($urandom_range(0, 1) == 1) ? random_letter() : random_digit());
		end
		line_q.push_back(CH_RPAREN);
	endfunction

	function automatic void add_word();
		line_q.push_back(random_letter());
		if ($urandom_range(0, 9) == 0)
			line_q.push_back(random_letter());
		if ($urandom_range(0, 2) == 0)
			line_q.push_back(CH_MINUS);
		repeat (digit_count()) begin
			if ($urandom_range(0, 19) == 0)
				add_comment();
			line_q.push_back(random_digit());
		end
		if ($urandom_range(0, 7) == 0)
			line_q.push_back(CH_MINUS);
		if ($urandom_range(0, 1) == 1) begin
			line_q.push_back(($urandom_range(0, 1) == 1) ? CH_DOT : CH_COMMA);
			repeat (digit_count()) line_q.push_back(random_digit());
			if ($urandom_range(0, 9) == 0)
				line_q.push_back(CH_MINUS);
		end
		if ($urandom_range(0, 7) == 0)
			line_q.push_back(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 9) == 0)
			add_comment();
	endfunction

	function automatic void queue_random_line();
		if ($urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(1, 10)) line_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 8)) add_word();
			if ($urandom_range(0, 29) == 0)
				line_q.push_back(CH_RPAREN);
		end
	endfunction

	task automatic send_byte(input logic [7:0] ch, input logic eol);
		if (tx_idle_on && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ch;
		s_axis_tlast  <= eol;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_queued();
		foreach (line_q[i])
			send_byte(line_q[i], i == line_q.size() - 1);
		line_q.delete();
	endtask

	task automatic drain_words();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.expected_words.size() != 0) @(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Lower case, a repeated letter, a second minus, a comment inside a word,
		// a minus in the fraction and an unmatched closing parenthesis on the last byte.
		queue_text("aB-12-(f)Y.5-Z)");
		send_queued();
		// Ignored bytes at both ends of the range, and a word closed by a letter on the last byte.
		line_q.push_back(8'hFF);
		line_q.push_back(8'h00);
		queue_text("M7x");
		send_queued();
		queue_text("f3,90");
		send_queued();

		while (bytes_sent < 1200) begin
			tx_idle_on  = $urandom_range(0, 3) != 0;
			rx_stall_on = $urandom_range(0, 3) != 0;
			queue_random_line();
			send_queued();
			if ($urandom_range(0, 7) == 0)
				drain_words();
		end

		// Long receiver hold-off while the sender keeps offering words.
		tx_idle_on = 1'b0;
		rx_hold_len = 400;
		repeat (20) queue_text("x1");
		send_queued();
		drain_words();

		tx_idle_on  = 1'b0;
		rx_stall_on = 1'b0;
		while (bytes_sent < 1650) begin
			queue_random_line();
			send_queued();
		end

		drain_words();
		repeat (20) @(posedge clk);
		if (tracker.failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+src
src/gwp_pkg.sv
src/gwp_core.sv
src/gcode_word_parser_top.sv
bench/gcode_word_parser_top_test.sv
